[rtl/pct_pkg.sv]
// ----------------------------------------------------------------------------
// Polygon convexity test: shared package
// Widths, the request record that runs from the front to the back, and the
// front state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

  localparam int COORD_BITS  = 16;
  localparam int NORMAL_BITS = 32;
  localparam int COUNT_W     = 8;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int DOT_W   = CROSS_W + NORMAL_BITS;
  localparam int SUM_W   = DOT_W + 2;

  localparam int IN_RAW_W   = 3 * COORD_BITS + 3 * NORMAL_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 1 + COUNT_W + 2;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] MIN_TURNS = COUNT_W'(3);

  typedef logic [2:0][COORD_BITS-1:0]  vec_t;
  typedef logic [2:0][NORMAL_BITS-1:0] nvec_t;

  typedef struct packed {
    logic               do_turn;
    logic               finish;
    logic [COUNT_W-1:0] count;
    logic               bad;
  } meta_t;

  typedef struct packed {
    meta_t meta;
    vec_t  p0;
    vec_t  p1;
    vec_t  p2;
    nvec_t nrm;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WRAP1,
    F_WRAP2
  } fstate_e;

endpackage

`default_nettype wire

[rtl/pct_front.sv]
// ----------------------------------------------------------------------------
// Polygon convexity test: front end
// Accepts vertices, keeps the face history and issues one turn request per
// vertex triple, plus two wrap-around triples (1-2 vertices: one final job).
// ----------------------------------------------------------------------------
`default_nettype none

module pct_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_valid_i,
  output logic                 s_ready_o,
  input  wire  pct_pkg::vec_t  cur_i,
  input  wire  pct_pkg::nvec_t nrm_i,
  input  wire                  index_ok_i,
  input  wire                  last_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output pct_pkg::job_t        job_o
);
  import pct_pkg::*;

  fstate_e            state_q, state_d;
  vec_t               first_q, first_d;
  vec_t               second_q, second_d;
  vec_t               older_q, older_d;
  vec_t               newer_q, newer_d;
  nvec_t              normal_q, normal_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               bad_q, bad_d;

  logic               take;
  logic               has_pair;
  logic [COUNT_W-1:0] count_n;
  logic               bad_n;

  assign has_pair = (count_q >= COUNT_W'(2));
  assign count_n  = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_W'(1);
  assign bad_n    = bad_q | ~index_ok_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (take && last_i && has_pair) begin
          state_d = F_WRAP1;
        end
      end
      F_WRAP1: begin
        if (!q_full_i) begin
          state_d = F_WRAP2;
        end
      end
      F_WRAP2: begin
        if (!q_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o         = 1'b0;
    push_o            = 1'b0;
    job_o.meta.do_turn = 1'b1;
    job_o.meta.finish  = 1'b0;
    job_o.meta.count   = count_n;
    job_o.meta.bad     = bad_n;
    job_o.p0          = older_q;
    job_o.p1          = newer_q;
    job_o.p2          = cur_i;
    job_o.nrm         = normal_q;
    case (state_q)
      F_IDLE: begin
        s_ready_o = ~q_full_i;
        if (s_valid_i && !q_full_i) begin
          if (!has_pair) begin
            push_o            = last_i;
            job_o.meta.do_turn = 1'b0;
            job_o.meta.finish  = 1'b1;
          end else begin
            push_o = 1'b1;
          end
        end
      end
      F_WRAP1: begin
        push_o   = ~q_full_i;
        job_o.p2 = first_q;
      end
      F_WRAP2: begin
        push_o            = ~q_full_i;
        job_o.p0          = newer_q;
        job_o.p1          = first_q;
        job_o.p2          = second_q;
        job_o.meta.finish = 1'b1;
        job_o.meta.count  = count_q;
        job_o.meta.bad    = bad_q;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  assign take = s_valid_i & s_ready_o;

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    older_d  = older_q;
    newer_d  = newer_q;
    normal_d = normal_q;
    count_d  = count_q;
    bad_d    = bad_q;
    if (take) begin
      if (count_q == '0) begin
        first_d  = cur_i;
        normal_d = nrm_i;
      end
      if (count_q == COUNT_W'(1)) begin
        second_d = cur_i;
      end
      older_d = newer_q;
      newer_d = cur_i;
      if (last_i && !has_pair) begin
        count_d = '0;
        bad_d   = 1'b0;
      end else begin
        count_d = count_n;
        bad_d   = bad_n;
      end
    end else if (state_q == F_WRAP2 && !q_full_i) begin
      count_d = '0;
      bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      first_q  <= '0;
      second_q <= '0;
      older_q  <= '0;
      newer_q  <= '0;
      normal_q <= '0;
      count_q  <= '0;
      bad_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      first_q  <= first_d;
      second_q <= second_d;
      older_q  <= older_d;
      newer_q  <= newer_d;
      normal_q <= normal_d;
      count_q  <= count_d;
      bad_q    <= bad_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pct_queue.sv]
// ----------------------------------------------------------------------------
// Polygon convexity test: request queue
// A short first-in first-out buffer of turn requests between the front end
// and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire  pct_pkg::job_t data_i,
  input  wire                 pop_i,
  output pct_pkg::job_t       data_o,
  output logic                full_o,
  output logic                empty_o
);
  import pct_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pct_back.sv]
// ----------------------------------------------------------------------------
// Polygon convexity test: back end
// Pipelined edge, cross product and normal dot product unit that collects the
// turn signs of a face and forms the face result into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pct_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  pct_pkg::job_t          job_i,
  input  wire                          q_empty_i,
  output logic                         pop_o,
  output logic                         m_valid_o,
  input  wire                          m_ready_i,
  output logic                         convex_o,
  output logic [pct_pkg::COUNT_W-1:0]  count_o,
  output logic [1:0]                   sense_o
);
  import pct_pkg::*;

  logic adv;

  logic v1_q, v2_q, v3_q, v4_q;
  meta_t m1_q, m2_q, m3_q, m4_q;
  nvec_t n1_q, n2_q, n3_q;

  logic signed [EDGE_W-1:0]  e1_q [3];
  logic signed [EDGE_W-1:0]  e2_q [3];
  logic signed [PROD_W-1:0]  pa_q [3];
  logic signed [PROD_W-1:0]  pb_q [3];
  logic signed [CROSS_W-1:0] c_q  [3];
  logic signed [DOT_W-1:0]   d_q  [3];
  logic signed [SUM_W-1:0]   sum;

  logic sum_neg, sum_pos, hit_pos, hit_neg, pos_all, neg_all;
  logic pos_q, pos_d, neg_q, neg_d;
  logic out_valid_q, out_valid_d;
  logic out_convex_q, out_convex_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  logic [1:0] out_sense_q, out_sense_d;

  assign adv   = ~out_valid_q | m_ready_i;
  assign pop_o = adv & ~q_empty_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= EDGE_W'($signed(job_i.p1[i])) - EDGE_W'($signed(job_i.p0[i]));
        e2_q[i] <= EDGE_W'($signed(job_i.p2[i])) - EDGE_W'($signed(job_i.p1[i]));
      end
      m1_q <= job_i.meta;
      n1_q <= job_i.nrm;

      pa_q[0] <= e1_q[1] * e2_q[2];
      pb_q[0] <= e1_q[2] * e2_q[1];
      pa_q[1] <= e1_q[2] * e2_q[0];
      pb_q[1] <= e1_q[0] * e2_q[2];
      pa_q[2] <= e1_q[0] * e2_q[1];
      pb_q[2] <= e1_q[1] * e2_q[0];
      m2_q <= m1_q;
      n2_q <= n1_q;

      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CROSS_W'(pa_q[i]) - CROSS_W'(pb_q[i]);
      end
      m3_q <= m2_q;
      n3_q <= n2_q;

      for (int i = 0; i < 3; i++) begin
        d_q[i] <= c_q[i] * $signed(n3_q[i]);
      end
      m4_q <= m3_q;
    end
  end

  assign sum     = SUM_W'(d_q[0]) + SUM_W'(d_q[1]) + SUM_W'(d_q[2]);
  assign sum_neg = sum[SUM_W-1];
  assign sum_pos = ~sum_neg & (|sum);
  assign hit_pos = m4_q.do_turn & sum_pos;
  assign hit_neg = m4_q.do_turn & sum_neg;
  assign pos_all = pos_q | hit_pos;
  assign neg_all = neg_q | hit_neg;

  always_comb begin
    pos_d        = pos_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q & ~m_ready_i;
    out_convex_d = out_convex_q;
    out_count_d  = out_count_q;
    out_sense_d  = out_sense_q;
    if (adv && v4_q) begin
      if (m4_q.finish) begin
        pos_d       = 1'b0;
        neg_d       = 1'b0;
        out_valid_d = 1'b1;
        out_count_d = m4_q.count;
        out_sense_d = m4_q.bad ? 2'b00 : {neg_all, pos_all};
        if (m4_q.count < MIN_TURNS) begin
          out_convex_d = 1'b0;
        end else if (m4_q.count == MIN_TURNS) begin
          out_convex_d = 1'b1;
        end else if (m4_q.bad) begin
          out_convex_d = 1'b0;
        end else begin
          out_convex_d = ~(pos_all & neg_all);
        end
      end else begin
        pos_d = pos_all;
        neg_d = neg_all;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_convex_q <= out_convex_d;
    out_count_q  <= out_count_d;
    out_sense_q  <= out_sense_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      pos_q       <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= ~q_empty_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      pos_q       <= pos_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign convex_o  = out_convex_q;
  assign count_o   = out_count_q;
  assign sense_o   = out_sense_q;

endmodule

`default_nettype wire

[rtl/polygon_convexity_test_core.sv]
// Path: after its last vertex is accepted, a face result passes the request
// queue, the edge, product, cross and dot registers and the output register.
// Throughput: one vertex per cycle while the request queue has room. The last
// vertex of a face of three or more stalls input for its wrap-around triples;
// the four-entry request queue and the output register set stalls.
// Reset: asynchronous, active low; clears the face state, queue and pipeline.
// ----------------------------------------------------------------------------
// Polygon convexity test core
// Streams face vertices and reports per face whether the polygon is convex,
// using an exact integer sign of the edge cross product against the normal.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_convexity_test_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // coord_x, coord_y, coord_z, normal_x, normal_y, normal_z
  input  wire  [pct_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // index_ok
  input  wire                              s_axis_tuser,
  input  wire                              s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // convex, vertex_count, turn_sense, zero padding
  output logic [pct_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import pct_pkg::*;

  vec_t               cur;
  nvec_t              nrm;
  logic               push;
  logic               pop;
  job_t               push_job;
  job_t               head_job;
  logic               q_full;
  logic               q_empty;
  logic               convex;
  logic [COUNT_W-1:0] count;
  logic [1:0]         sense;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign cur[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
    assign nrm[i] = s_axis_tdata[3*COORD_BITS + i*NORMAL_BITS +: NORMAL_BITS];
  end

  pct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .cur_i      (cur),
    .nrm_i      (nrm),
    .index_ok_i (s_axis_tuser),
    .last_i     (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  pct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pct_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_i     (head_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .convex_o  (convex),
    .count_o   (count),
    .sense_o   (sense)
  );

  assign m_axis_tdata = OUT_DATA_W'({sense, count, convex});

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("Request pushed into a full queue.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("Request popped from an empty queue.");

  a_wrap_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast && push && !push_job.meta.finish)
      |=> !s_axis_tready)
    else $error("Input accepted while wrap-around requests are pending.");

  a_short_face_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !push_job.meta.do_turn) |-> push_job.meta.finish)
    else $error("Request without a turn that does not close a face.");

endmodule

`default_nettype wire

[sim/tb_polygon_convexity_test_core.sv]
// ----------------------------------------------------------------------------
// Polygon convexity test core: testbench
// Streams faces into the core and follows every accepted vertex with an
// exact integer model of the turn signs. The model predicts each face
// verdict, and every verdict the core returns is checked field by field
// against it. Directed faces come first, then two very long faces and a long
// output stall, then random faces. Random idle cycles are inserted on both
// sides of the core.
// ----------------------------------------------------------------------------
module tb_polygon_convexity_test_core;

  import pct_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int VERTEX_TARGET = 1750;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [1:0] TURN_NONE  = 2'b00;
  localparam logic [1:0] TURN_POS   = 2'b01;
  localparam logic [1:0] TURN_NEG   = 2'b10;
  localparam logic [1:0] TURN_MIXED = 2'b11;

  typedef logic signed [COORD_BITS-1:0]  coord3_t [3];
  typedef logic signed [NORMAL_BITS-1:0] normal3_t [3];

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
    logic signed [COORD_BITS-1:0]  z;
    logic signed [NORMAL_BITS-1:0] nx;
    logic signed [NORMAL_BITS-1:0] ny;
    logic signed [NORMAL_BITS-1:0] nz;
    logic                          index_ok;
    logic                          last;
  } vertex_t;

  typedef struct packed {
    logic               convex;
    logic [COUNT_W-1:0] count;
    logic [1:0]         sense;
  } verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  polygon_convexity_test_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  coord3_t            first_pt;
  coord3_t            second_pt;
  coord3_t            older_pt;
  coord3_t            newer_pt;
  normal3_t           face_nrm;
  logic [COUNT_W-1:0] face_count;
  logic [1:0]         face_turns;
  logic               face_bad;

  verdict_t pending_verdicts [$];
  vertex_t  face_buf [$];

  int  vertices_sent;
  int  fault_count;
  int  cycle_count;
  bit  quiet_tx;
  int  hold_requests;
  int  hold_served;
  int  rx_wait;
  int  rx_open;
  int  rx_pick;
  verdict_t got_verdict;
  verdict_t want_verdict;

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (quiet_tx || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return stall_len();
  endfunction

  // Sign of ((b - a) x (c - b)) . n, computed exactly at full width.
  function automatic logic [1:0] turn_sign(input coord3_t a, input coord3_t b,
                                           input coord3_t c);
    longint e1 [3];
    longint e2 [3];
    longint cr [3];
    logic signed [127:0] dot;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(b[i]) - longint'(a[i]);
      e2[i] = longint'(c[i]) - longint'(b[i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      dot = dot + $signed(cr[i]) * $signed(face_nrm[i]);
    end
    if (dot < 0) begin
      return TURN_NEG;
    end else if (dot != 0) begin
      return TURN_POS;
    end
    return TURN_NONE;
  endfunction

  task automatic track_vertex(input vertex_t v);
    coord3_t  cur;
    verdict_t res;
    cur[0] = v.x;
    cur[1] = v.y;
    cur[2] = v.z;
    if (face_count == 0) begin
      first_pt    = cur;
      face_nrm[0] = v.nx;
      face_nrm[1] = v.ny;
      face_nrm[2] = v.nz;
    end else if (face_count == 1) begin
      second_pt = cur;
    end else begin
      face_turns = face_turns | turn_sign(older_pt, newer_pt, cur);
    end
    older_pt = newer_pt;
    newer_pt = cur;
    if (face_count != COUNT_MAX) begin
      face_count = face_count + 1'b1;
    end
    if (!v.index_ok) begin
      face_bad = 1'b1;
    end
    if (v.last) begin
      if (face_count >= 3) begin
        face_turns = face_turns | turn_sign(older_pt, newer_pt, first_pt);
        face_turns = face_turns | turn_sign(newer_pt, first_pt, second_pt);
      end
      res.count = face_count;
      if (face_count < 3) begin
        res.convex = 1'b0;
      end else if (face_count == 3) begin
        res.convex = 1'b1;
      end else if (face_bad) begin
        res.convex = 1'b0;
      end else begin
        res.convex = (face_turns != TURN_MIXED);
      end
      res.sense = face_bad ? TURN_NONE : face_turns;
      pending_verdicts = {pending_verdicts, res};
      face_count = '0;
      face_turns = TURN_NONE;
      face_bad   = 1'b0;
    end
  endtask

  task automatic send_vertex(input vertex_t v);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({v.nz, v.ny, v.nx, v.z, v.y, v.x});
    s_axis_tuser  <= v.index_ok;
    s_axis_tlast  <= v.last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_vertex(v);
    vertices_sent++;
  endtask

  task automatic add_vertex(input int x, input int y, input int z, input bit ok);
    vertex_t v;
    v          = '0;
    v.x        = COORD_BITS'(x);
    v.y        = COORD_BITS'(y);
    v.z        = COORD_BITS'(z);
    v.index_ok = ok;
    face_buf   = {face_buf, v};
  endtask

  // Later vertices carry random normals, which the core must ignore.
  task automatic send_face(input int nx, input int ny, input int nz);
    vertex_t v;
    for (int i = 0; i < face_buf.size(); i++) begin
      v = face_buf[i];
      if (i == 0) begin
        v.nx = nx;
        v.ny = ny;
        v.nz = nz;
      end else begin
        v.nx = $urandom;
        v.ny = $urandom;
        v.nz = $urandom;
      end
      v.last = (i == face_buf.size() - 1);
      send_vertex(v);
    end
    face_buf.delete();
  endtask

  // Points on a parabola in a random plane, taken in order, form a convex face.
  task automatic queue_curved_face(input int n);
    int ts [$];
    int ux, uy, uz, vx, vy, vz, ox, oy, oz;
    int tv, start, j;
    bit rev;
    ux = $urandom_range(0, 80) - 40;
    uy = $urandom_range(0, 80) - 40;
    uz = $urandom_range(0, 80) - 40;
    vx = $urandom_range(0, 80) - 40;
    vy = $urandom_range(0, 80) - 40;
    vz = $urandom_range(0, 80) - 40;
    ox = $urandom_range(0, 16000) - 8000;
    oy = $urandom_range(0, 16000) - 8000;
    oz = $urandom_range(0, 16000) - 8000;
    tv = $urandom_range(0, 4) - 20;
    while (ts.size() < n && tv <= 20) begin
      ts = {ts, tv};
      tv += $urandom_range(1, 3);
    end
    rev   = $urandom_range(0, 1);
    start = $urandom_range(0, ts.size() - 1);
    for (int k = 0; k < ts.size(); k++) begin
      j  = (start + k) % ts.size();
      if (rev) begin
        j = ts.size() - 1 - j;
      end
      tv = ts[j];
      add_vertex(ox + tv * ux + tv * tv * vx, oy + tv * uy + tv * tv * vy,
                 oz + tv * uz + tv * tv * vz, 1'b1);
    end
    face_normal_from(ux, uy, uz, vx, vy, vz);
  endtask

  task automatic face_normal_from(input int ux, input int uy, input int uz,
                                  input int vx, input int vy, input int vz);
    int cx, cy, cz, sh;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    sh = $urandom_range(0, 19);
    if ($urandom_range(0, 99) < 20) begin
      send_face($urandom, $urandom, $urandom);
    end else if ($urandom_range(0, 1)) begin
      send_face(-(cx <<< sh), -(cy <<< sh), -(cz <<< sh));
    end else begin
      send_face(cx <<< sh, cy <<< sh, cz <<< sh);
    end
  endtask

  task automatic test_small_faces();
    add_vertex(-32768, 32767, 123, 1'b1);
    send_face(32'h8000_0000, 32'h7fff_ffff, 0);
    add_vertex(5, 6, 7, 1'b1);
    add_vertex(-5, -6, -7, 1'b0);
    send_face(1, 1, 1);
  endtask

  task automatic test_triangles();
    add_vertex(0, 0, 0, 1'b1);
    add_vertex(10, 0, 0, 1'b1);
    add_vertex(0, 10, 0, 1'b1);
    send_face(0, 0, 1);
    add_vertex(0, 0, 0, 1'b1);
    add_vertex(0, 10, 3, 1'b0);
    add_vertex(10, 0, -3, 1'b1);
    send_face(5, -7, 9);
  endtask

  task automatic test_quads();
    add_vertex(1, 1, 1, 1'b1);
    add_vertex(2, 2, 2, 1'b1);
    add_vertex(3, 3, 3, 1'b1);
    add_vertex(4, 4, 4, 1'b1);
    send_face(1, 2, 3);
    add_vertex(0, 0, 0, 1'b1);
    add_vertex(100, 0, 5, 1'b1);
    add_vertex(10, 10, -5, 1'b1);
    add_vertex(0, 100, 0, 1'b1);
    send_face(0, 0, 32'h8000_0000);
    add_vertex(-32768, -32768, 0, 1'b1);
    add_vertex(32767, -32768, 0, 1'b1);
    add_vertex(32767, 32767, 0, 1'b1);
    add_vertex(-32768, 32767, 0, 1'b1);
    send_face(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_vertex(32767, 0, -32768, 1'b1);
    add_vertex(-32768, 32767, 32767, 1'b1);
    add_vertex(0, -32768, 32767, 1'b0);
    add_vertex(-1, -1, -1, 1'b1);
    send_face(32'hffff_ffff, 0, 32'h8000_0000);
  endtask

  task automatic test_count_saturation();
    for (int i = 0; i < 300; i++) begin
      add_vertex($urandom, $urandom, $urandom, 1'b1);
    end
    send_face($urandom, $urandom, $urandom);
    for (int i = 0; i < 260; i++) begin
      add_vertex(i - 130, 2 * i, -i, 1'b1);
    end
    send_face(7, -3, 11);
  endtask

  // The receiver holds off while short faces are offered back to back.
  task automatic test_output_stall();
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
    quiet_tx = 1'b1;
    for (int i = 0; i < 60; i++) begin
      queue_curved_face($urandom_range(3, 4));
    end
    quiet_tx = 1'b0;
  endtask

  task automatic test_random_faces();
    int kind, n, ox, oy, oz, ux, uy, uz;
    while (vertices_sent < VERTEX_TARGET) begin
      kind     = $urandom_range(0, 99);
      quiet_tx = ($urandom_range(0, 99) < 15);
      if (kind < 60) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(3, 12);
        queue_curved_face(n);
      end else if (kind < 85) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          add_vertex($urandom, $urandom, $urandom, $urandom_range(0, 19) != 0);
        end
        send_face($urandom, $urandom, $urandom);
      end else if (kind < 95) begin
        n  = $urandom_range(2, 8);
        ox = $urandom_range(0, 2000) - 1000;
        oy = $urandom_range(0, 2000) - 1000;
        oz = $urandom_range(0, 2000) - 1000;
        ux = $urandom_range(0, 20) - 10;
        uy = $urandom_range(0, 20) - 10;
        uz = $urandom_range(0, 20) - 10;
        for (int i = 0; i < n; i++) begin
          add_vertex(ox + i * ux, oy + i * uy, oz + i * uz, 1'b1);
        end
        send_face($urandom, $urandom, $urandom);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          add_vertex($urandom, $urandom, $urandom, $urandom_range(0, 1));
        end
        send_face($urandom, $urandom, $urandom);
      end
    end
    quiet_tx = 1'b0;
  endtask

  task automatic report_fault(input string what, input verdict_t want, input verdict_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s: expected convex=%0d count=%0d sense=%0d, got convex=%0d count=%0d sense=%0d",
               what, want.convex, want.count, want.sense, got.convex, got.count, got.sense);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_verdict.convex = m_axis_tdata[0];
      got_verdict.count  = m_axis_tdata[COUNT_W:1];
      got_verdict.sense  = m_axis_tdata[COUNT_W+2:COUNT_W+1];
      if (pending_verdicts.size() == 0) begin
        report_fault("Unexpected verdict", '0, got_verdict);
      end else begin
        want_verdict = pending_verdicts.pop_front();
        if (got_verdict.convex !== want_verdict.convex ||
            got_verdict.count !== want_verdict.count ||
            got_verdict.sense !== want_verdict.sense) begin
          report_fault("Verdict mismatch", want_verdict, got_verdict);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      rx_wait     = HOLD_CYCLES;
      rx_open     = 0;
    end
    if (rx_wait > 0) begin
      m_axis_tready <= 1'b0;
      rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_open > 0) begin
        rx_open--;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 10) begin
          rx_open = $urandom_range(20, 80);
        end else if (rx_pick < 35) begin
          rx_wait = stall_len();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    face_count    = '0;
    face_turns    = TURN_NONE;
    face_bad      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      first_pt[i]  = '0;
      second_pt[i] = '0;
      older_pt[i]  = '0;
      newer_pt[i]  = '0;
      face_nrm[i]  = '0;
    end
    vertices_sent = 0;
    fault_count   = 0;
    cycle_count   = 0;
    quiet_tx      = 1'b0;
    hold_requests = 0;
    hold_served   = 0;
    rx_wait       = 0;
    rx_open       = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_small_faces();
    test_triangles();
    test_quads();
    test_count_saturation();
    test_output_stall();
    test_random_faces();

    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
